>>> src/ffa_pkg.sv
// ffa_pkg: shared widths, operation codes, state type and default sizes
// for the first-fit block allocator. No dependencies.
`default_nettype none

package ffa_pkg;

  // field widths of the channels, the config register and the header memory
  localparam int OP_W  = 2;
  localparam int REQ_W = 12;
  localparam int OFF_W = 12;
  localparam int CFG_W = 13;
  localparam int HDR_W = 14;

  // default sizing
  localparam int POOL_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 8;

  // pool length register after reset
  localparam logic [CFG_W-1:0] POOL_LEN_RST = 13'd4096;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EVAL,
    ST_SPLIT,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_POST
  } state_t;

endpackage

`default_nettype wire

>>> src/ffa_in_if.sv
// ffa_in_if: request channel of the allocator (valid, ready, payload).
// Depends on ffa_pkg for the field widths.
`default_nettype none

interface ffa_in_if import ffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] block_offset;

  modport source (output valid, output operation, output request_bytes,
                  output block_offset, input ready);
  modport sink   (input valid, input operation, input request_bytes,
                  input block_offset, output ready);
endinterface

`default_nettype wire

>>> src/ffa_out_if.sv
// ffa_out_if: result channel of the allocator (valid, ready, payload).
// Depends on ffa_pkg for the field widths.
`default_nettype none

interface ffa_out_if import ffa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] payload_offset;

  modport source (output valid, output found, output payload_offset, input ready);
  modport sink   (input valid, input found, input payload_offset, output ready);
endinterface

`default_nettype wire

>>> src/first_fit_variable_block_allocator.sv
// first_fit_variable_block_allocator: first-fit allocator over a chunk chain
// kept in one single-port header memory. Depends on ffa_pkg, ffa_in_if, ffa_out_if.
//
// Usage: in_ch carries one item per transfer (allocate, free or init); out_ch
// returns exactly one result per item, in order. cfg_we/cfg_wdata write the
// pool length, which bounds the chunk walk and the size that init formats.
// Items are worked one at a time; allocate and free do a read-modify-write of
// the header memory, which has a registered read:
//   allocate: a walk and an evaluate state per chunk header visited along the
//             chain, plus the split state if the chunk is split, plus a last
//             walk state when the walk ends without a fit, then post, idle
//   free:     read header, write negated header, post, idle (bad offset: post, idle)
//   init:     the clearing sweep of the memory, then post, idle
//   others:   post, idle (also a zero-byte allocate)
// After reset a clearing pass over the whole header memory formats the pool as one
// free chunk; in_ch.ready stays low meanwhile, config writes are taken.
// Results go to an output register; the next item is accepted while a result
// waits, and a finished item holds in post until out_ch.ready or the register is empty.
`default_nettype none

module first_fit_variable_block_allocator
  import ffa_pkg::*;
#(
  parameter int POOL_BYTES   = POOL_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  ffa_in_if.sink                in_ch,
  ffa_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(POOL_BYTES);
  localparam int PW  = (((AW + 1) > CFG_W) ? (AW + 1) : CFG_W) + 2;
  localparam int RST_EFF = (POOL_BYTES < int'(POOL_LEN_RST)) ? POOL_BYTES
                                                             : int'(POOL_LEN_RST);
  localparam logic [PW-1:0]    POOL_PW  = PW'(POOL_BYTES);
  localparam logic [PW-1:0]    H_PW     = PW'(HEADER_BYTES);
  localparam logic [AW-1:0]    LAST_ADR = AW'(POOL_BYTES - 1);
  localparam logic [HDR_W-1:0] FMT_RST  = HDR_W'(RST_EFF - HEADER_BYTES);

  // registers
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   pool_len_r;
  logic [HDR_W-1:0]   fmt_r, fmt_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               clr_item_r, clr_item_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [HDR_W-1:0]   split_val_r, split_val_nxt;
  logic               res_found_r, res_found_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [OFF_W-1:0]   out_off_r;

  // header memory
  logic [HDR_W-1:0]   mem [POOL_BYTES];
  logic [HDR_W-1:0]   rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [HDR_W-1:0]   mem_wdata;

  // decision terms
  logic               in_xfer;
  logic               slot_free;
  logic [PW-1:0]      pe_w;
  logic [HDR_W-1:0]   fmt_w;
  logic               walk_ok;
  logic [HDR_W:0]     s_ext;
  logic [HDR_W:0]     need_h;
  logic [HDR_W:0]     mag;
  logic               fit_split;
  logic               fit_whole;
  logic [PW-1:0]      nh_w;
  logic               split_in_pool;
  logic [PW-1:0]      blk_w;
  logic [PW-1:0]      free_adr;
  logic               free_ok;
  logic               clr_last;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // effective pool size and the header that formatting writes
  assign pe_w  = (PW'(pool_len_r) > POOL_PW) ? POOL_PW : PW'(pool_len_r);
  assign fmt_w = (pe_w > H_PW) ? HDR_W'(pe_w - H_PW) : '0;

  // chain walk terms
  assign walk_ok   = ((pos_r + PW'(req_r)) < pe_w) && (pos_r < POOL_PW);
  assign s_ext     = {rd_data_r[HDR_W-1], rd_data_r};
  assign need_h    = (HDR_W+1)'(req_r) + (HDR_W+1)'(HEADER_BYTES);
  assign mag       = rd_data_r[HDR_W-1] ? ((HDR_W+1)'(0) - s_ext) : s_ext;
  assign fit_split = $signed(s_ext) > $signed(need_h);
  assign fit_whole = (s_ext == (HDR_W+1)'(req_r)) || (s_ext == need_h);
  assign nh_w      = pos_r + H_PW + PW'(req_r);
  assign split_in_pool = nh_w < POOL_PW;

  // free address check
  assign blk_w    = PW'(in_ch.block_offset);
  assign free_adr = blk_w - H_PW;
  assign free_ok  = (blk_w >= H_PW) && (free_adr < POOL_PW);

  assign clr_last = clr_cnt_r == LAST_ADR;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_item_r ? ST_POST : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.operation)
            OP_ALLOC: state_nxt = (in_ch.request_bytes == '0) ? ST_POST : ST_WALK;
            OP_FREE:  state_nxt = free_ok ? ST_FREE_RD : ST_POST;
            OP_INIT:  state_nxt = ST_CLEAR;
            default:  state_nxt = ST_POST;
          endcase
        end
      end
      ST_WALK:    state_nxt = walk_ok ? ST_EVAL : ST_POST;
      ST_EVAL: begin
        if (fit_split) begin
          state_nxt = split_in_pool ? ST_SPLIT : ST_POST;
        end else if (fit_whole) begin
          state_nxt = ST_POST;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_SPLIT:   state_nxt = ST_POST;
      ST_FREE_RD: state_nxt = ST_FREE_WR;
      ST_FREE_WR: state_nxt = ST_POST;
      ST_POST: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs: memory port and input ready
  always_comb begin
    mem_we      = 1'b0;
    mem_addr    = pos_r[AW-1:0];
    mem_wdata   = '0;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = (clr_cnt_r == '0) ? fmt_r : '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_EVAL: begin
        if (fit_split) begin
          mem_we    = 1'b1;
          mem_wdata = HDR_W'(0) - HDR_W'(req_r);
        end else if (fit_whole) begin
          mem_we    = 1'b1;
          mem_wdata = HDR_W'(0) - rd_data_r;
        end
      end
      ST_SPLIT: begin
        mem_we    = 1'b1;
        mem_addr  = nh_w[AW-1:0];
        mem_wdata = split_val_r;
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = HDR_W'(0) - rd_data_r;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    fmt_nxt       = fmt_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_item_nxt  = clr_item_r;
    pos_nxt       = pos_r;
    req_nxt       = req_r;
    split_val_nxt = split_val_r;
    res_found_nxt = res_found_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_last) begin
          res_found_nxt = 1'b1;
          res_off_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          res_found_nxt = 1'b0;
          res_off_nxt   = '0;
          req_nxt       = in_ch.request_bytes;
          pos_nxt       = '0;
          case (in_ch.operation)
            OP_FREE: begin
              pos_nxt = free_adr;
            end
            OP_INIT: begin
              fmt_nxt      = fmt_w;
              clr_cnt_nxt  = '0;
              clr_item_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (fit_split || fit_whole) begin
          res_found_nxt = 1'b1;
          res_off_nxt   = OFF_W'(pos_r + H_PW);
          split_val_nxt = HDR_W'(s_ext - need_h);
        end else begin
          pos_nxt = pos_r + PW'(mag) + H_PW;
        end
      end
      ST_FREE_WR: begin
        res_found_nxt = 1'b1;
      end
      ST_POST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pool_len_r  <= POOL_LEN_RST;
      fmt_r       <= FMT_RST;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fmt_r       <= fmt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pool_len_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    req_r       <= req_nxt;
    split_val_r <= split_val_nxt;
    res_found_r <= res_found_nxt;
    res_off_r   <= res_off_nxt;
    if (state_r == ST_POST && slot_free) begin
      out_found_r <= res_found_r;
      out_off_r   <= res_off_r;
    end
  end

  // header memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.payload_offset = out_off_r;

endmodule

`default_nettype wire

>>> dv/ffa_result_checker.sv
// ffa_result_checker: watches the request, result and config ports of the
// first-fit allocator, predicts every result and compares it in order.
// Depends on ffa_pkg, ffa_in_if and ffa_out_if.
module ffa_result_checker
  import ffa_pkg::*;
#(
  parameter int POOL_BYTES   = POOL_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ffa_in_if                in_ch,
  ffa_out_if               out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int unsigned      fail_count,
  output int unsigned      awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] payload_offset;
  } alloc_result_t;

  // predicted header store and pool size register
  logic signed [HDR_W-1:0] chunk_hdr [POOL_BYTES];
  logic [CFG_W-1:0]        pool_bytes_cfg;
  alloc_result_t           expected_results [$];
  int unsigned             result_idx;

  // pool size as the walk sees it, capped at the memory size
  function automatic int unsigned usable_pool();
    return (pool_bytes_cfg > POOL_BYTES) ? POOL_BYTES : pool_bytes_cfg;
  endfunction

  // whole pool becomes one free chunk, everything else cleared
  function automatic void format_pool();
    int unsigned p;
    p = usable_pool();
    for (int i = 0; i < POOL_BYTES; i++) chunk_hdr[i] = '0;
    chunk_hdr[0] = (p > HEADER_BYTES) ? HDR_W'(p - HEADER_BYTES) : '0;
  endfunction

  // walk the chain from offset 0 and take the first chunk that fits
  function automatic logic first_fit(input int unsigned n, output logic [OFF_W-1:0] grant_at);
    int unsigned pos, lim, split_at, mag;
    int          s, need, need_h;
    pos      = 0;
    lim      = usable_pool();
    need     = n;
    need_h   = n + HEADER_BYTES;
    grant_at = '0;
    if (n == 0) return 1'b0;
    while (pos + n < lim && pos < POOL_BYTES) begin
      s = chunk_hdr[pos];
      // larger chunk: split, new free header after the payload
      if (s > need_h) begin
        split_at       = pos + HEADER_BYTES + n;
        chunk_hdr[pos] = HDR_W'(-need);
        if (split_at < POOL_BYTES) chunk_hdr[split_at] = HDR_W'(s - need_h);
        grant_at = OFF_W'(pos + HEADER_BYTES);
        return 1'b1;
      end
      // exact fit or fit with one header to spare: taken whole
      if (s == need || s == need_h) begin
        chunk_hdr[pos] = HDR_W'(-s);
        grant_at       = OFF_W'(pos + HEADER_BYTES);
        return 1'b1;
      end
      mag = (s < 0) ? -s : s;
      pos += mag + HEADER_BYTES;
    end
    return 1'b0;
  endfunction

  // apply one request to the predicted state and return its result
  function automatic alloc_result_t apply_item(input logic [OP_W-1:0] op,
                                               input logic [REQ_W-1:0] req,
                                               input logic [OFF_W-1:0] offs);
    alloc_result_t    r;
    logic [OFF_W-1:0] grant_at;
    int unsigned      hdr_at;
    r = '0;
    case (op)
      OP_ALLOC: begin
        r.found          = first_fit(req, grant_at);
        r.payload_offset = grant_at;
      end
      OP_FREE: begin
        // offsets inside the first header are ignored
        if (offs >= HEADER_BYTES) begin
          hdr_at = offs - HEADER_BYTES;
          if (hdr_at < POOL_BYTES) begin
            chunk_hdr[hdr_at] = -chunk_hdr[hdr_at];
            r.found           = 1'b1;
          end
        end
      end
      OP_INIT: begin
        format_pool();
        r.found = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, what);
  endfunction

  // predict on request transfers, compare on result transfers
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst_n) begin
      pool_bytes_cfg = POOL_LEN_RST;
      format_pool();
      expected_results.delete();
      fail_count = 0;
      result_idx = 0;
    end else begin
      if (cfg_we) pool_bytes_cfg = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.found          = out_ch.found;
        got.payload_offset = out_ch.payload_offset;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("result %0d arrived with nothing expected: found=%0b offset=%0d",
                                result_idx, got.found, got.payload_offset));
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.payload_offset !== want.payload_offset)
            log_failure($sformatf({"result %0d mismatch: expected found=%0b offset=%0d, ",
                                   "got found=%0b offset=%0d"}, result_idx, want.found,
                                  want.payload_offset, got.found, got.payload_offset));
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(apply_item(in_ch.operation, in_ch.request_bytes,
                                              in_ch.block_offset));
    end
    awaited_count = expected_results.size();
  end

endmodule

>>> dv/tb_first_fit_variable_block_allocator.sv
// tb_first_fit_variable_block_allocator: drives requests, result backpressure and
// pool size writes into the allocator; ffa_result_checker does the comparing.
// Depends on ffa_pkg, ffa_in_if, ffa_out_if, ffa_result_checker and the RTL.
module tb_first_fit_variable_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int              POOL_BYTES   = POOL_BYTES_DEF;
  localparam int              HEADER_BYTES = HEADER_BYTES_DEF;
  localparam int unsigned     CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned     DRAIN_CYCLES = 64;
  localparam int unsigned     MAX_IDLE     = 8;
  localparam int              NUM_PHASES   = 7;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      chk_failures;
  int unsigned      chk_awaited;

  ffa_in_if  in_ch ();
  ffa_out_if out_ch ();

  first_fit_variable_block_allocator #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  ffa_result_checker #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) result_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (chk_failures),
    .awaited_count(chk_awaited)
  );

  // pool size per phase, 0 draws one at random; one phase skips the init
  int unsigned phase_pool  [NUM_PHASES] = '{16, 4, 8191, 300, 300, 4096, 0};
  bit          phase_init  [NUM_PHASES] = '{1, 1, 1, 0, 1, 1, 1};
  int unsigned phase_items [NUM_PHASES] = '{30, 20, 200, 80, 120, 250, 130};

  int unsigned      cycle_count;
  int unsigned      items_sent, results_seen, grants;
  int unsigned      n_alloc, n_free, n_init, n_unused;
  bit               send_burst, recv_burst;
  logic [OFF_W-1:0] live_blocks [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, items_sent - results_seen);
      $display("TEST FAILED");
      $finish;
    end
  end

  // count result transfers and keep granted offsets for later frees
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.found && out_ch.payload_offset != '0) begin
        grants++;
        live_blocks.push_back(out_ch.payload_offset);
      end
    end
  end

  // result side backpressure: random stall before each transfer, with bursts
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 23) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
      @(negedge clk) out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // idle gap before an item, ends on a falling edge
  task automatic hold_off();
    int unsigned gap;
    if ($urandom_range(0, 23) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // present one item and wait for its transfer
  task automatic offer_item(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                            input logic [OFF_W-1:0] offs);
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.request_bytes <= req;
    in_ch.block_offset  <= offs;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
    case (op)
      OP_ALLOC: n_alloc++;
      OP_FREE:  n_free++;
      OP_INIT:  n_init++;
      default:  n_unused++;
    endcase
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                           input logic [OFF_W-1:0] offs);
    hold_off();
    offer_item(op, req, offs);
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    @(negedge clk) in_ch.valid <= 1'b0;
    wait (results_seen == items_sent);
  endtask

  task automatic set_pool_size(input int unsigned bytes);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(bytes);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // mostly allocate/free traffic on granted blocks, plus noise
  task automatic send_random_item(input int unsigned pool);
    int unsigned      pick, size_cap, idx;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] offs;
    hold_off();
    pick     = $urandom_range(0, 99);
    req      = REQ_W'($urandom);
    offs     = OFF_W'($urandom);
    size_cap = (pool < 16) ? 16 : ((pool > 4095) ? 4095 : pool);
    if (pick < 55) begin
      case ($urandom_range(0, 19))
        0:       req = REQ_W'($urandom_range(0, 4095));
        1, 2, 3: req = REQ_W'($urandom_range(1, size_cap));
        default: req = REQ_W'($urandom_range(1, 32));
      endcase
      offer_item(OP_ALLOC, req, offs);
    end else if (pick < 88) begin
      if (live_blocks.size() > 0 && $urandom_range(0, 9) != 0) begin
        idx  = $urandom_range(0, live_blocks.size() - 1);
        offs = live_blocks[idx];
        live_blocks.delete(idx);
      end else if ($urandom_range(0, 1) == 0) begin
        offs = OFF_W'($urandom_range(0, HEADER_BYTES - 1));
      end
      offer_item(OP_FREE, req, offs);
    end else if (pick < 91) begin
      live_blocks.delete();
      offer_item(OP_INIT, req, offs);
    end else if (pick < 94) begin
      offer_item(OP_UNUSED, req, offs);
    end else begin
      req = REQ_W'($urandom_range(1, HEADER_BYTES));
      offer_item(OP_ALLOC, req, offs);
    end
  endtask

  initial begin
    int unsigned pool;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.block_offset  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: pool of 4096 bytes formatted by reset
    send_item(OP_ALLOC, 12'd0, 12'd0);        // zero request
    send_item(OP_ALLOC, 12'd4095, 12'd0);     // larger than any chunk
    send_item(OP_ALLOC, 12'd4080, 12'd0);     // request plus header, taken whole
    send_item(OP_ALLOC, 12'd1, 12'd0);        // chain fully allocated
    send_item(OP_FREE, 12'd0, 12'd8);
    send_item(OP_ALLOC, 12'd4088, 12'd0);     // exact fit
    send_item(OP_FREE, 12'd0, 12'd8);
    send_item(OP_ALLOC, 12'd1, 12'd0);        // split
    send_item(OP_ALLOC, 12'd4079, 12'd0);     // exact fit of the remainder
    send_item(OP_FREE, 12'd0, 12'd17);
    send_item(OP_FREE, 12'd0, 12'd17);        // double free flips it back
    send_item(OP_FREE, 12'd0, 12'd0);         // below header
    send_item(OP_FREE, 12'd0, 12'd7);
    send_item(OP_FREE, 12'd4095, 12'd4095);   // non-header entry
    send_item(OP_FREE, 12'd0, 12'd100);
    send_item(OP_UNUSED, 12'd4095, 12'd4095);
    send_item(OP_UNUSED, 12'd0, 12'd0);
    send_item(OP_INIT, 12'd4095, 12'd4095);
    send_item(OP_ALLOC, 12'd4095, 12'd4095);
    send_item(OP_ALLOC, 12'd1, 12'd0);
    send_item(OP_ALLOC, 12'd1, 12'd0);
    send_item(OP_ALLOC, 12'd1, 12'd0);
    send_item(OP_FREE, 12'd0, 12'd17);
    send_item(OP_ALLOC, 12'd1, 12'd0);        // reuses the freed chunk

    // random phases over several pool sizes, each begun from idle
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pool = phase_pool[ph];
      if (pool == 0) pool = $urandom_range(16, 4096);
      set_pool_size(pool);
      if (phase_init[ph]) begin
        live_blocks.delete();
        send_item(OP_INIT, REQ_W'($urandom), OFF_W'($urandom));
      end
      repeat (phase_items[ph]) send_random_item(pool);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d allocate (%0d granted), %0d free, %0d init, %0d unused op",
             items_sent, n_alloc, grants, n_free, n_init, n_unused);
    $display("pool sizes from tiny to oversized, one phase walking an unreformatted pool");
    if (chk_failures == 0 && chk_awaited == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results never arrived", chk_failures, chk_awaited);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
